### src/cap_pkg.sv
// Types and constants for the cascaded autopilot block.
// No dependencies.
`default_nettype none
package cap_pkg;
   typedef enum logic [2:0] {
      ST_IDLE, ST_WRAP, ST_MUL, ST_SUM, ST_SPLIT, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic wrap;
      logic mul;
      logic sum;
      logic split;
      logic [2:0] mul_sel;
      logic out_load;
   } cmd_type;

   localparam int unsigned HdgFull = 92160;
   localparam int unsigned RollHalf = 46080;
   localparam int unsigned AilLim = 1280;
   localparam int unsigned ClimbLim = 204800;
   localparam int unsigned ElevLim = 6144;

   localparam logic [2:0] MUL_ALT = 3'd0;
   localparam logic [2:0] MUL_KP = 3'd1;
   localparam logic [2:0] MUL_KD = 3'd2;
   localparam logic [2:0] MUL_KI = 3'd3;
   localparam logic [2:0] MUL_CLIMB = 3'd4;

   localparam logic [2:0] CSR_ENGAGED = 3'd0;
   localparam logic [2:0] CSR_TGT_HDG = 3'd1;
   localparam logic [2:0] CSR_TGT_ALT = 3'd2;
   localparam logic [2:0] CSR_HEAD_KP = 3'd3;
   localparam logic [2:0] CSR_HEAD_KD = 3'd4;
   localparam logic [2:0] CSR_HEAD_KI = 3'd5;
   localparam logic [2:0] CSR_ALT_KP = 3'd6;
   localparam logic [2:0] CSR_CLIMB_KP = 3'd7;
endpackage
`default_nettype wire

### src/cap_ctrl.sv
// Sequencer for the autopilot datapath.
// Depends on cap_pkg.
`default_nettype none
module cap_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output cap_pkg::cmd_type    cmd
);
   import cap_pkg::*;
   state_type state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_WRAP;
         ST_WRAP: begin
            state_in = ST_MUL;
            cnt_in = MUL_ALT;
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == MUL_CLIMB) state_in = ST_SUM;
         end
         ST_SUM: state_in = ST_SPLIT;
         ST_SPLIT: state_in = ST_OUT;
         ST_OUT: if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: cmd.load = req_valid;
         ST_WRAP: cmd.wrap = 1'b1;
         ST_MUL: begin
            cmd.mul = 1'b1;
            cmd.mul_sel = cnt_ff;
         end
         ST_SUM: cmd.sum = 1'b1;
         ST_SPLIT: cmd.split = 1'b1;
         ST_OUT: cmd.out_load = !rsp_valid_ff || !rsp_stall;
         default: cmd = '0;
      endcase
   end

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (!rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

### src/cap_dp.sv
// Datapath: wraps, shared multiplier, clamps and aileron split.
// Depends on cap_pkg.
`default_nettype none
module cap_dp (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cap_pkg::cmd_type    cmd,
   input  wire logic                engaged,
   input  wire logic        [16:0]  target_heading,
   input  wire logic signed [23:0]  target_altitude,
   input  wire logic        [15:0]  head_kp,
   input  wire logic        [15:0]  head_kd,
   input  wire logic        [15:0]  head_ki,
   input  wire logic        [15:0]  alt_kp,
   input  wire logic        [15:0]  climb_kp,
   input  wire logic signed [18:0]  heading_meas,
   input  wire logic signed [17:0]  roll_meas,
   input  wire logic signed [22:0]  climb_rate,
   input  wire logic signed [23:0]  altitude,
   output logic signed [11:0]       left_aileron,
   output logic signed [11:0]       right_aileron,
   output logic signed [13:0]       elevator
);
   import cap_pkg::*;
   logic signed [18:0] h_ff;
   logic signed [17:0] r_ff;
   logic signed [22:0] vs_ff;
   logic signed [23:0] alt_ff;
   logic [16:0] last_ff;
   logic signed [31:0] integ_ff;
   logic signed [19:0] err_ff;
   logic signed [18:0] der_ff;
   logic signed [19:0] s_ff;
   logic signed [63:0] pid_ff;
   logic signed [48:0] ct_ff;
   logic signed [13:0] elev_ff;
   logic signed [11:0] left_ff, right_ff, left_o_ff, right_o_ff;
   logic signed [13:0] elev_o_ff;
   logic signed [35:0] rerr_ff;

   logic signed [19:0] hw, rw;
   logic signed [19:0] err_w;
   logic signed [32:0] isum;
   logic signed [9:0] erem;
   logic signed [49:0] prod;
   logic signed [32:0] ma;
   logic signed [16:0] mb;
   logic signed [63:0] pidc;
   logic signed [39:0] roll_tgt;
   logic signed [48:0] ctc;
   logic signed [40:0] ctf;
   logic signed [41:0] re;
   logic signed [40:0] ev;
   logic signed [23:0] tri7;
   logic signed [43:0] q10;
   logic signed [19:0] sneg;
   logic signed [19:0] sl, sr;

   always_comb begin
      hw = 20'(h_ff);
      if (h_ff > 19'sd92160) begin
         if (h_ff >= 19'sd184320) hw = 20'(h_ff) - 20'sd184320;
         else hw = 20'(h_ff) - 20'sd92160;
      end
      if (h_ff < 19'sd0) begin
         if (h_ff <= -19'sd184320) hw = 20'(h_ff) + 20'sd276480;
         else if (h_ff <= -19'sd92160) hw = 20'(h_ff) + 20'sd184320;
         else hw = 20'(h_ff) + 20'sd92160;
      end
      rw = 20'(r_ff);
      if (r_ff > 18'sd46080) begin
         if (r_ff >= 18'sd92160) rw = 20'(r_ff) - 20'sd138240;
         else rw = 20'(r_ff) - 20'sd92160;
      end
      if (r_ff < -18'sd46080) begin
         if (r_ff <= -18'sd92160) rw = 20'(r_ff) + 20'sd138240;
         else rw = 20'(r_ff) + 20'sd92160;
      end
      err_w = $signed({3'b0, target_heading}) - hw;
      erem = 10'(err_w % 20'sd512);
      isum = 33'(integ_ff) + 33'(erem);
   end

   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.mul_sel)
         MUL_KP: begin ma = 33'(err_ff); mb = $signed({1'b0, head_kp}); end
         MUL_KD: begin ma = 33'(der_ff); mb = $signed({1'b0, head_kd}); end
         MUL_KI: begin ma = 33'(integ_ff); mb = $signed({1'b0, head_ki}); end
         MUL_ALT: begin
            ma = 33'(alt_ff) - 33'(target_altitude);
            mb = $signed({1'b0, alt_kp});
         end
         default: begin
            ma = 33'(rerr_ff);
            mb = $signed({1'b0, climb_kp});
         end
      endcase
      prod = 50'(ma * mb);
   end

   always_comb begin
      pidc = pid_ff;
      if (pid_ff > (64'sd20 <<< 24)) pidc = 64'sd20 <<< 24;
      if (pid_ff < -(64'sd20 <<< 24)) pidc = -(64'sd20 <<< 24);
      roll_tgt = 40'(pidc >>> 16);
      ctc = -ct_ff;
      if (ctc > 49'sd52428800) ctc = 49'sd52428800;
      if (ctc < -49'sd52428800) ctc = -49'sd52428800;
      ctf = 41'(ctc >>> 8);
      re = 42'(vs_ff) - 42'(ctf);
      if (re > 42'sd204800) re = 42'sd204800;
      if (re < -42'sd204800) re = -42'sd204800;
      ev = 41'(prod >>> 16);
      sneg = -s_ff;
      tri7 = (s_ff > 0) ? 24'(s_ff) * 24'sd7 : 24'(sneg) * 24'sd7;
      q10 = 44'(tri7) * 44'sd419431;
      if (s_ff > 0) begin
         sl = 20'(q10 >>> 22);
         sr = sneg;
         if (sl > 20'sd1280) sl = 20'sd1280;
         if (sr < -20'sd1280) sr = -20'sd1280;
      end else begin
         sl = s_ff;
         sr = 20'(q10 >>> 22);
         if (sl < -20'sd1280) sl = -20'sd1280;
         if (sr > 20'sd1280) sr = 20'sd1280;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
         integ_ff <= '0;
      end else if (cmd.wrap) begin
         last_ff <= 17'(hw);
         if (!engaged) integ_ff <= '0;
         else if (isum > 33'sd2147483647) integ_ff <= 32'sh7fffffff;
         else if (isum < -33'sd2147483648) integ_ff <= 32'sh80000000;
         else integ_ff <= 32'(isum);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         h_ff <= heading_meas;
         r_ff <= roll_meas;
         vs_ff <= climb_rate;
         alt_ff <= altitude;
      end
      if (cmd.wrap) begin
         err_ff <= err_w;
         der_ff <= 19'(hw - $signed({3'b0, last_ff}));
         r_ff <= 18'(rw);
      end
      if (cmd.mul) begin
         case (cmd.mul_sel)
            MUL_KP: begin
               pid_ff <= 64'(prod) <<< 8;
               rerr_ff <= 36'(re);
            end
            MUL_KD: pid_ff <= pid_ff + (64'(prod) <<< 8);
            MUL_KI: pid_ff <= pid_ff + 64'(prod);
            MUL_ALT: ct_ff <= 49'(prod);
            default: begin
               if (ev > 41'sd6144) elev_ff <= 14'sd6144;
               else if (ev < -41'sd6144) elev_ff <= -14'sd6144;
               else elev_ff <= 14'(ev);
            end
         endcase
      end
      if (cmd.sum) s_ff <= 20'(roll_tgt) - 20'(r_ff);
      if (cmd.split) begin
         left_ff <= 12'(sl);
         right_ff <= 12'(sr);
      end
      if (cmd.out_load) begin
         left_o_ff <= left_ff;
         right_o_ff <= right_ff;
         elev_o_ff <= elev_ff;
      end
   end

   assign left_aileron = left_o_ff;
   assign right_aileron = right_o_ff;
   assign elevator = elev_o_ff;
endmodule
`default_nettype wire

### src/cascaded_autopilot_pid_top.sv
// Top level of the cascaded autopilot: registers, sequencer, datapath.
// Depends on cap_pkg, cap_ctrl, cap_dp.
//
// channel | direction | handshake
// req     | in        | req_valid / req_stall
// rsp     | out       | rsp_valid / rsp_stall
// csr     | in        | csr_write, csr_index, csr_data
//
// After a transaction is accepted, its result passes through wrap,
// five passes through the one shared multiplier, sum, split and output load.
// The input is not taken again until the sequencer is back in idle after the output load.
// A stalled result holds the sequencer before the output load, stalling the input.
// Reset is synchronous, stalls the input and restores register defaults.
`default_nettype none
module cascaded_autopilot_pid_top (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write,
   input  wire logic        [2:0]   csr_index,
   input  wire logic        [23:0]  csr_data,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic signed [18:0]  req_heading_meas,
   input  wire logic signed [17:0]  req_roll_meas,
   input  wire logic signed [22:0]  req_climb_rate,
   input  wire logic signed [23:0]  req_altitude,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [11:0]       rsp_left_aileron,
   output logic signed [11:0]       rsp_right_aileron,
   output logic signed [13:0]       rsp_elevator
);
   import cap_pkg::*;
   cmd_type cmd;
   logic engaged_ff;
   logic [16:0] tgt_hdg_ff;
   logic signed [23:0] tgt_alt_ff;
   logic [15:0] head_kp_ff, head_kd_ff, head_ki_ff, alt_kp_ff, climb_kp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         engaged_ff <= 1'b0;
         tgt_hdg_ff <= '0;
         tgt_alt_ff <= '0;
         head_kp_ff <= 16'd256;
         head_kd_ff <= 16'd2560;
         head_ki_ff <= 16'd655;
         alt_kp_ff <= 16'd12800;
         climb_kp_ff <= 16'd328;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ENGAGED: engaged_ff <= csr_data[0];
            CSR_TGT_HDG: tgt_hdg_ff <= csr_data[16:0];
            CSR_TGT_ALT: tgt_alt_ff <= $signed(csr_data);
            CSR_HEAD_KP: head_kp_ff <= csr_data[15:0];
            CSR_HEAD_KD: head_kd_ff <= csr_data[15:0];
            CSR_HEAD_KI: head_ki_ff <= csr_data[15:0];
            CSR_ALT_KP: alt_kp_ff <= csr_data[15:0];
            CSR_CLIMB_KP: climb_kp_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   cap_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .cmd(cmd)
   );

   cap_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .engaged(engaged_ff),
      .target_heading(tgt_hdg_ff), .target_altitude(tgt_alt_ff),
      .head_kp(head_kp_ff), .head_kd(head_kd_ff), .head_ki(head_ki_ff),
      .alt_kp(alt_kp_ff), .climb_kp(climb_kp_ff),
      .heading_meas(req_heading_meas), .roll_meas(req_roll_meas),
      .climb_rate(req_climb_rate), .altitude(req_altitude),
      .left_aileron(rsp_left_aileron), .right_aileron(rsp_right_aileron),
      .elevator(rsp_elevator)
   );
endmodule
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench for cascaded_autopilot_pid_top: directed table, then random ticks.
// Holds its own predictor of the heading, roll and altitude loops; depends on cap_pkg and the RTL.
`timescale 1ns / 100ps
module tb_top;
   import cap_pkg::*;

   localparam longint HDG = 92160;
   localparam longint ROLL = 46080;
   localparam longint AIL = 1280;
   localparam longint CLB = 204800;
   localparam longint ELV = 6144;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [11:0] left;
      logic signed [11:0] right;
      logic signed [13:0] elev;
   } surface_type;

   typedef struct {
      longint hdg, roll, vs, alt;
      bit     typed;
      surface_type want;
   } tick_row_type;

   logic clock, reset;
   logic csr_write;
   logic [2:0] csr_index;
   logic [23:0] csr_data;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   logic signed [18:0] req_heading_meas;
   logic signed [17:0] req_roll_meas;
   logic signed [22:0] req_climb_rate;
   logic signed [23:0] req_altitude;
   logic signed [11:0] rsp_left_aileron, rsp_right_aileron;
   logic signed [13:0] rsp_elevator;

   bit          cur_typed;
   surface_type cur_want;
   surface_type surface_q[$];
   int          n_errors;
   longint      n_cycles;
   int          gap_max;
   bit          hold_long;

   longint engaged, tgt_hdg, tgt_alt, hd_kp, hd_kd, hd_ki, al_kp, cl_kp;
   longint last_hdg, integ;

   cascaded_autopilot_pid_top u_dut (.*);

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic longint floor_div(longint x, longint d);
      if (x >= 0) return x / d;
      return -((-x + d - 1) / d);
   endfunction

   function automatic longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic surface_type predict_tick(longint h, longint r, longint vs, longint alt);
      longint err, der, pid, s, l, rt, ctgt, rerr, el;
      surface_type o;
      if (h > HDG) h = h % HDG;
      if (h < 0) h = h % HDG + HDG;
      if (r > ROLL) r = r % ROLL - ROLL;
      if (r < -ROLL) r = r % ROLL + ROLL;
      err = tgt_hdg - h;
      der = h - last_hdg;
      last_hdg = h;
      if (engaged == 0) integ = 0;
      else integ = clip(integ + err % 512, -64'sd2147483648, 64'sd2147483647);
      pid = (hd_kp * err + hd_kd * der) * 256 + hd_ki * integ;
      pid = floor_div(clip(pid, -(64'sd20 <<< 24), 64'sd20 <<< 24), 65536);
      s = pid - r;
      if (s > 0) begin
         l = clip((7 * s) / 10, -longint'(1) <<< 40, AIL);
         rt = -s;
         if (rt < -AIL) rt = -AIL;
      end else begin
         l = s;
         if (l < -AIL) l = -AIL;
         rt = (7 * (-s)) / 10;
         if (rt > AIL) rt = AIL;
      end
      ctgt = -al_kp * (alt - tgt_alt);
      ctgt = floor_div(clip(ctgt, -CLB * 256, CLB * 256), 256);
      rerr = clip(vs - ctgt, -CLB, CLB);
      el = clip(floor_div(cl_kp * rerr, 65536), -ELV, ELV);
      o.left = l[11:0];
      o.right = rt[11:0];
      o.elev = el[13:0];
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d, expected %0d at cycle %0d", what, got, want, n_cycles);
      n_errors++;
   endtask

   // predict on request acceptance
   always @(posedge clock) begin
      surface_type o;
      if (!reset && req_valid && !req_stall) begin
         o = predict_tick(req_heading_meas, req_roll_meas, req_climb_rate, req_altitude);
         if (cur_typed) o = cur_want;
         surface_q.push_back(o);
      end
   end

   // compare on result acceptance
   always @(posedge clock) begin
      surface_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (surface_q.size() == 0) begin
            report_mismatch("pending transactions", 0, 1);
         end else begin
            w = surface_q.pop_front();
            if (rsp_left_aileron !== w.left)
               report_mismatch("left_aileron", rsp_left_aileron, w.left);
            if (rsp_right_aileron !== w.right)
               report_mismatch("right_aileron", rsp_right_aileron, w.right);
            if (rsp_elevator !== w.elev)
               report_mismatch("elevator", rsp_elevator, w.elev);
         end
      end
   end

   // receiver: random stall per transaction, long hold on request
   initial begin
      int n;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_long) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            hold_long = 1'b0;
         end else begin
            n = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) n = 0;
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
            end
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
      end
   end

   task automatic write_reg(logic [2:0] idx, longint val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val[23:0];
      case (idx)
         CSR_ENGAGED:  engaged = val & 1;
         CSR_TGT_HDG:  tgt_hdg = val & 'h1FFFF;
         CSR_TGT_ALT:  tgt_alt = longint'($signed(val[23:0]));
         CSR_HEAD_KP:  hd_kp = val & 'hFFFF;
         CSR_HEAD_KD:  hd_kd = val & 'hFFFF;
         CSR_HEAD_KI:  hd_ki = val & 'hFFFF;
         CSR_ALT_KP:   al_kp = val & 'hFFFF;
         default:      cl_kp = val & 'hFFFF;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      while (surface_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic send_tick(tick_row_type t);
      int n;
      n = $urandom_range(0, gap_max);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_heading_meas <= t.hdg[18:0];
      req_roll_meas <= t.roll[17:0];
      req_climb_rate <= t.vs[22:0];
      req_altitude <= t.alt[23:0];
      cur_typed <= t.typed;
      cur_want <= t.want;
      @(posedge clock);
      while (!(req_valid && !req_stall)) @(posedge clock);
   endtask

   function automatic longint pick(longint lo, longint hi, longint wlo, longint whi);
      if ($urandom_range(0, 4) == 0) return wlo + longint'($urandom_range(0, whi - wlo));
      return lo + longint'($urandom_range(0, hi - lo));
   endfunction

   function automatic tick_row_type random_tick();
      tick_row_type t;
      t.hdg = pick(-92159, 184319, -262144, 262143);
      t.roll = pick(-92159, 92159, -131072, 131071);
      t.vs = pick(-2560000, 2560000, -4194304, 4194303);
      if ($urandom_range(0, 2) == 0) t.alt = tgt_alt + pick(-4000, 4000, -4000, 4000);
      else t.alt = pick(-256000, 5120000, -8388608, 8388607);
      t.typed = 0;
      return t;
   endfunction

   initial begin
      tick_row_type dir_tab[$];
      tick_row_type t;
      longint hi_vals[8];
      reset = 1'b1;
      n_cycles = 0;
      n_errors = 0;
      gap_max = 7;
      hold_long = 1'b0;
      csr_write = 1'b0;
      csr_index = CSR_ENGAGED;
      csr_data = '0;
      req_valid = 1'b0;
      req_heading_meas = '0;
      req_roll_meas = '0;
      req_climb_rate = '0;
      req_altitude = '0;
      cur_typed = 1'b0;
      cur_want = '{0, 0, 0};
      engaged = 0; tgt_hdg = 0; tgt_alt = 0;
      hd_kp = 256; hd_kd = 2560; hd_ki = 655; al_kp = 12800; cl_kp = 328;
      last_hdg = 0; integ = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_tab.push_back('{0, 0, 0, 0, 1, '{0, 0, 0}});
      dir_tab.push_back('{0, 0, 2560000, 0, 1, '{0, 0, 1025}});
      dir_tab.push_back('{0, 0, -2560000, 0, 1, '{0, 0, -1025}});
      dir_tab.push_back('{0, 0, 0, 5120000, 1, '{0, 0, 1025}});
      dir_tab.push_back('{0, 46080, 0, 0, 1, '{-1280, 1280, 0}});
      dir_tab.push_back('{92160, 0, 0, -256000, 0, '{0, 0, 0}});
      dir_tab.push_back('{-92160, -46080, 0, 0, 0, '{0, 0, 0}});
      dir_tab.push_back('{184319, 92159, 0, 0, 0, '{0, 0, 0}});
      dir_tab.push_back('{-92159, -92159, 0, 0, 0, '{0, 0, 0}});
      dir_tab.push_back('{92161, 46081, 100, 0, 0, '{0, 0, 0}});
      dir_tab.push_back('{-1, -46081, -100, 0, 0, '{0, 0, 0}});
      dir_tab.push_back('{262143, 131071, 4194303, 8388607, 0, '{0, 0, 0}});
      dir_tab.push_back('{-262144, -131072, -4194304, -8388608, 0, '{0, 0, 0}});
      dir_tab.push_back('{45000, 1000, 0, 256, 0, '{0, 0, 0}});
      dir_tab.push_back('{44000, -1000, 5000, -256, 0, '{0, 0, 0}});
      dir_tab.push_back('{0, 0, 0, 0, 0, '{0, 0, 0}});
      foreach (dir_tab[i]) send_tick(dir_tab[i]);
      req_valid <= 1'b0;
      drain();

      // engaged with extreme gains and targets
      write_reg(CSR_ENGAGED, 1);
      write_reg(CSR_TGT_HDG, 131071);
      write_reg(CSR_TGT_ALT, 5120000);
      write_reg(CSR_HEAD_KP, 65535);
      write_reg(CSR_HEAD_KD, 65535);
      write_reg(CSR_HEAD_KI, 65535);
      write_reg(CSR_ALT_KP, 65535);
      write_reg(CSR_CLIMB_KP, 65535);
      csr_write <= 1'b0;
      hold_long = 1'b1;
      gap_max = 0;
      for (int i = 0; i < 100; i++) begin
         if (i == 40) gap_max = 7;
         send_tick(random_tick());
      end
      req_valid <= 1'b0;
      drain();

      write_reg(CSR_TGT_HDG, 0);
      write_reg(CSR_TGT_ALT, -256000);
      write_reg(CSR_HEAD_KP, 0);
      write_reg(CSR_HEAD_KD, 0);
      write_reg(CSR_HEAD_KI, 0);
      write_reg(CSR_ALT_KP, 0);
      write_reg(CSR_CLIMB_KP, 0);
      csr_write <= 1'b0;
      for (int i = 0; i < 50; i++) send_tick(random_tick());
      req_valid <= 1'b0;
      drain();

      // random settings, integral active across long sequences in all but the last pass
      for (int p = 0; p < 5; p++) begin
         hi_vals[0] = (p != 4);
         hi_vals[1] = $urandom_range(0, 92160);
         hi_vals[2] = pick(-256000, 5120000, -256000, 5120000);
         for (int k = 3; k < 8; k++) hi_vals[k] = $urandom_range(0, 4096);
         hi_vals[5] = $urandom_range(0, 65535);
         for (int k = 0; k < 8; k++) write_reg(k[2:0], hi_vals[k]);
         csr_write <= 1'b0;
         for (int i = 0; i < 50; i++) begin
            t = random_tick();
            if ($urandom_range(0, 3) != 0) t.hdg = tgt_hdg + pick(-3000, 3000, -3000, 3000);
            send_tick(t);
         end
         req_valid <= 1'b0;
         drain();
      end

      if (n_errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
